// File: hw/rtl/bale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bale_pkg;

  // Index width for cell positions and counts, enough for up to 2047 cells
  localparam int unsigned IDX_W = 11;
  localparam int unsigned DATA_W = 32;

  // Operation codes on the input item
  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_SET    = 3'd3,
    FN_GET    = 3'd4,
    FN_MEMBER = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_POS   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic CFG_LOWER = 1'b0;
  localparam logic CFG_UPPER = 1'b1;

  // What every cell does at each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  // Broadcast control seen by every cell of the chain
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   at;
    logic [IDX_W-1:0]   count;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bale_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bale_cell #(
  parameter int IDX = 0
) (
  input  wire logic                              clk,
  input  wire bale_pkg::cell_ctl_t               ctl,
  input  wire logic [bale_pkg::DATA_W-1:0]       key,
  input  wire logic [bale_pkg::DATA_W-1:0]       left_data,
  input  wire logic [bale_pkg::DATA_W-1:0]       right_data,
  output logic      [bale_pkg::DATA_W-1:0]       data,
  output logic                                   match,
  output logic      [bale_pkg::DATA_W-1:0]       rd_data
);

  localparam logic [bale_pkg::IDX_W-1:0] MY_IDX = bale_pkg::IDX_W'(IDX);

  logic [bale_pkg::DATA_W-1:0] data_r;
  logic [bale_pkg::DATA_W-1:0] data_nxt;

  // Pick the next entry: shift from a neighbor, load the key, or hold
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      bale_pkg::CELL_INSERT: begin
        if (MY_IDX > ctl.at) begin
          data_nxt = left_data;
        end else if (MY_IDX == ctl.at) begin
          data_nxt = key;
        end
      end
      bale_pkg::CELL_REMOVE: begin
        if (MY_IDX >= ctl.at) begin
          data_nxt = right_data;
        end
      end
      bale_pkg::CELL_WRITE: begin
        if (MY_IDX == ctl.at) begin
          data_nxt = key;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Local compare for search, and select for read
  assign match   = (MY_IDX < ctl.count) && (data_r == key);
  assign rd_data = (MY_IDX == ctl.at) ? data_r : '0;
  assign data    = data_r;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted item's result is registered straight into the output register.
// Throughput: one item per cycle when not stalled; every cell of the chain shifts,
//   loads or compares in the same cycle, so each operation finishes in a single step.
// An input item is stalled only while a previous result waits on a stalled output.
// Reset clears the list length and both bounds; entries hold no reset value.

module bounded_array_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_read_value,
  output logic             out_found,
  output logic [6:0]       out_length,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic signed [31:0]   lower_r;
  logic signed [31:0]   upper_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [31:0]          out_read_value_r;
  logic                 out_found_r;
  logic [6:0]           out_length_r;

  logic                 accept;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_ext;
  logic                 pos_bad;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        ins_at;
  logic                 in_rng;
  logic                 full;
  bale_pkg::func_t      fn;

  bale_pkg::status_t    status;
  bale_pkg::cell_op_t   op;
  logic [CW-1:0]        at;
  logic                 use_rd;
  logic                 use_found;
  bale_pkg::cell_ctl_t  ctl;

  logic [bale_pkg::DATA_W-1:0] cell_data  [CAPACITY];
  logic [bale_pkg::DATA_W-1:0] cell_rd    [CAPACITY];
  logic                        cell_match [CAPACITY];
  logic [bale_pkg::DATA_W-1:0] rd_any;
  logic                        found_any;

  // Handshakes
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Decode position and range checks
  assign fn      = bale_pkg::func_t'(in_func);
  assign pos_ext = PW'(in_position);
  assign cnt_ext = PW'(count_r);
  assign pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign idx     = CW'(pos_ext - PW'(1));
  assign ins_at  = ((fn == bale_pkg::FN_INSERT) && (pos_ext < cnt_ext)) ? CW'(pos_ext) : count_r;
  assign in_rng  = ($signed(in_value) >= lower_r) && ($signed(in_value) < upper_r);
  assign full    = (count_r == CW'(CAPACITY));

  // Operation decoder
  always_comb begin
    status    = bale_pkg::ST_OK;
    op        = bale_pkg::CELL_HOLD;
    at        = idx;
    count_nxt = count_r;
    use_rd    = 1'b0;
    use_found = 1'b0;
    unique case (fn) inside
      bale_pkg::FN_APPEND, bale_pkg::FN_INSERT: begin
        at = ins_at;
        if (!in_rng) begin
          status = bale_pkg::ST_RANGE;
        end else if (full) begin
          status = bale_pkg::ST_FULL;
        end else begin
          op        = bale_pkg::CELL_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      bale_pkg::FN_REMOVE: begin
        if (pos_bad) begin
          status = bale_pkg::ST_POS;
        end else begin
          op        = bale_pkg::CELL_REMOVE;
          count_nxt = count_r - CW'(1);
        end
      end
      bale_pkg::FN_SET: begin
        if (pos_bad) begin
          status = bale_pkg::ST_POS;
        end else begin
          op = bale_pkg::CELL_WRITE;
        end
      end
      bale_pkg::FN_GET: begin
        if (pos_bad) begin
          status = bale_pkg::ST_POS;
        end else begin
          use_rd = 1'b1;
        end
      end
      bale_pkg::FN_MEMBER: begin
        if (!in_rng) begin
          status = bale_pkg::ST_RANGE;
        end else begin
          use_found = 1'b1;
        end
      end
      default: begin
        status = bale_pkg::ST_OK;
      end
    endcase
  end

  // Broadcast to the chain; cells only change on an accepted item
  assign ctl.op    = accept ? op : bale_pkg::CELL_HOLD;
  assign ctl.at    = bale_pkg::IDX_W'(at);
  assign ctl.count = bale_pkg::IDX_W'(count_r);

  // Row of cells, each linked to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [bale_pkg::DATA_W-1:0] left_d;
    logic [bale_pkg::DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    bale_cell #(
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (in_value),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_data[g]),
      .match     (cell_match[g]),
      .rd_data   (cell_rd[g])
    );
  end

  // Combine per-cell read and search answers
  always_comb begin
    rd_any    = '0;
    found_any = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any    = rd_any | cell_rd[i];
      found_any = found_any | cell_match[i];
    end
  end

  // Length and bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lower_r <= '0;
      upper_r <= '0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bale_pkg::CFG_LOWER) begin
          lower_r <= $signed(cfg_data);
        end else begin
          upper_r <= $signed(cfg_data);
        end
      end
    end
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= status;
      out_read_value_r <= use_rd ? rd_any : '0;
      out_found_r      <= use_found && found_any;
      out_length_r     <= 7'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_found      = out_found_r;
  assign out_length     = out_length_r;

endmodule

`default_nettype wire

// File: hw/rtl/bale_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bale_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_read_value,
  input wire logic        out_found,
  input wire logic [6:0]  out_length
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_read_value) && $stable(out_length))
    else $error("stalled result changed");

  // Every accepted item gives a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // Length never exceeds the store
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_length) <= 32'(CAPACITY)))
    else $error("length past capacity");

  // A failed operation reads nothing and finds nothing
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bale_pkg::ST_OK) |-> (out_read_value == '0) && !out_found)
    else $error("failed operation returned data");

endmodule

bind bounded_array_list_engine bale_checker #(
  .CAPACITY(CAPACITY)
) u_bale_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_read_value(out_read_value),
  .out_found     (out_found),
  .out_length    (out_length)
);

`default_nettype wire

// File: sim/tb_bounded_array_list_engine.sv
`timescale 1ns / 1ps

module tb_bounded_array_list_engine;

  localparam int LIST_CAP = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 5;

  // Function codes the block leaves unused
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    bale_pkg::status_t status;
    logic [31:0]       read_value;
    logic              found;
    logic [6:0]        length;
  } list_result_t;

  // Shadow list plus the queue of results owed by the block
  class list_scoreboard;
    logic [31:0]        cells [LIST_CAP];
    int                 count;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    list_result_t       expected_q [$];
    int                 errors;

    function new();
      count = 0;
      lower = '0;
      upper = '0;
      errors = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit in_bounds(logic [31:0] v);
      return ($signed(v) >= lower) && ($signed(v) < upper);
    endfunction

    function void write_bound(logic idx, logic [31:0] d);
      if (idx == bale_pkg::CFG_LOWER) lower = d;
      else upper = d;
    endfunction

    // Apply one item to the shadow list and queue the result it owes
    function void note_item(logic [2:0] f, logic [6:0] p, logic [31:0] v);
      list_result_t r;
      int at;
      r.status = bale_pkg::ST_OK;
      r.read_value = '0;
      r.found = 1'b0;
      case (f) inside
        bale_pkg::FN_APPEND, bale_pkg::FN_INSERT: begin
          if (!in_bounds(v)) begin
            r.status = bale_pkg::ST_RANGE;
          end else if (count >= LIST_CAP) begin
            r.status = bale_pkg::ST_FULL;
          end else begin
            // insert at or past the end appends
            at = (f == bale_pkg::FN_INSERT && int'(p) < count) ? int'(p) : count;
            for (int i = count; i > at; i--) cells[i] = cells[i-1];
            cells[at] = v;
            count++;
          end
        end
        bale_pkg::FN_REMOVE: begin
          if (p == 0 || int'(p) > count) begin
            r.status = bale_pkg::ST_POS;
          end else begin
            for (int i = int'(p); i < count; i++) cells[i-1] = cells[i];
            count--;
          end
        end
        bale_pkg::FN_SET: begin
          if (p == 0 || int'(p) > count) r.status = bale_pkg::ST_POS;
          else cells[int'(p) - 1] = v;
        end
        bale_pkg::FN_GET: begin
          if (p == 0 || int'(p) > count) r.status = bale_pkg::ST_POS;
          else r.read_value = cells[int'(p) - 1];
        end
        bale_pkg::FN_MEMBER: begin
          if (!in_bounds(v)) begin
            r.status = bale_pkg::ST_RANGE;
          end else begin
            for (int i = 0; i < count; i++) begin
              if (cells[i] == v) r.found = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.length = 7'(count);
      expected_q.push_back(r);
    endfunction

    // Compare one result with the oldest owed result
    task check_result(logic [1:0] st, logic [31:0] rd, logic fd, logic [6:0] len);
      list_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no item waiting: status %0d length %0d",
                                  st, len));
      end else begin
        e = expected_q.pop_front();
        if (st !== e.status)
          report_mismatch($sformatf("status got %0d want %0d", st, e.status));
        if (rd !== e.read_value)
          report_mismatch($sformatf("read_value got %h want %h", rd, e.read_value));
        if (fd !== e.found)
          report_mismatch($sformatf("found got %0d want %0d", fd, e.found));
        if (len !== e.length)
          report_mismatch($sformatf("length got %0d want %0d", len, e.length));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [6:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic        out_found;
  logic [6:0]  out_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = bale_pkg::CFG_LOWER;
  logic [31:0] cfg_data = '0;

  list_scoreboard sb;
  int     in_idle_pct = 0;
  int     out_stall_pct = 0;
  int     idle_cycles = 0;
  longint cur_lo = 0;
  longint cur_hi = 0;

  bounded_array_list_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_found     (out_found),
    .out_length    (out_length),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Check results before noting a new item so the oldest expectation is used
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_read_value, out_found, out_length);
      if (in_valid && !in_stall)
        sb.note_item(in_func, in_position, in_value);
      if (cfg_valid && cfg_ready)
        sb.write_bound(cfg_index, cfg_data);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and hold it until accepted; return at a falling edge
  task automatic send_item(logic [2:0] f, logic [6:0] p, logic [31:0] v);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_position <= p;
    in_value    <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Drain the block, then write both bounds
  task automatic set_bounds(logic [31:0] lo, logic [31:0] hi);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= bale_pkg::CFG_LOWER;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= bale_pkg::CFG_UPPER;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_lo = longint'($signed(lo));
    cur_hi = longint'($signed(hi));
  endtask

  // Mostly in-range values, some stored values, bound edges and noise
  function automatic logic [31:0] pick_value();
    int unsigned k;
    longint span;
    longint r;
    k = $urandom_range(99);
    span = cur_hi - cur_lo;
    r = $urandom;
    if (span <= 0 || k < 8) return $urandom;
    if (k < 30 && sb.count != 0) return sb.cells[$urandom_range(sb.count - 1)];
    if (k < 34) return 32'(cur_lo);
    if (k < 38) return 32'(cur_hi - 1);
    if (k < 42) return 32'(cur_hi);
    if (k < 46) return 32'(cur_lo - 1);
    return 32'(cur_lo + r % span);
  endfunction

  // One-based position, mostly inside the list
  function automatic logic [6:0] pick_slot();
    int unsigned k;
    k = $urandom_range(99);
    if (sb.count != 0 && k < 80) return 7'($urandom_range(sb.count, 1));
    if (k < 88) return 7'd0;
    return 7'($urandom_range(127));
  endfunction

  // Random traffic that swings the list between empty and full
  task automatic run_random(int n_items);
    int unsigned k;
    logic [2:0]  f;
    logic [6:0]  p;
    logic [31:0] v;
    bit          grow;
    grow = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (sb.count == 0) grow = 1'b1;
      else if (sb.count == LIST_CAP && $urandom_range(7) == 0) grow = 1'b0;
      k = $urandom_range(99);
      p = pick_slot();
      v = pick_value();
      if (k < 4) begin
        f = 3'($urandom_range(7));
        p = 7'($urandom_range(127));
        v = $urandom;
      end else if (k < (grow ? 70 : 22)) begin
        f = ($urandom_range(1) != 0) ? bale_pkg::FN_APPEND : bale_pkg::FN_INSERT;
        if ($urandom_range(99) < 85) p = 7'($urandom_range(sb.count + 1));
        else p = 7'($urandom_range(127));
      end else if (k < 76 || (!grow && k < 70)) begin
        f = bale_pkg::FN_REMOVE;
      end else if (k < 84) begin
        f = bale_pkg::FN_SET;
        if ($urandom_range(3) == 0) v = $urandom;
      end else if (k < 92) begin
        f = bale_pkg::FN_GET;
      end else begin
        f = bale_pkg::FN_MEMBER;
      end
      send_item(f, p, v);
    end
  endtask

  task automatic run_directed();
    // reset bounds reject every addition and search
    send_item(bale_pkg::FN_APPEND, 7'd0, 32'd5);
    send_item(bale_pkg::FN_MEMBER, 7'd0, 32'd0);
    send_item(bale_pkg::FN_REMOVE, 7'd1, 32'd0);
    send_item(bale_pkg::FN_GET, 7'd0, 32'd0);
    send_item(FN_SPARE_6, 7'd127, INT_MAX);
    send_item(FN_SPARE_7, 7'd64, INT_MIN);
    set_bounds(INT_MIN, INT_MAX);
    send_item(bale_pkg::FN_APPEND, 7'd0, INT_MIN);
    send_item(bale_pkg::FN_APPEND, 7'd0, INT_MAX - 32'd1);
    // upper bound itself is out of range
    send_item(bale_pkg::FN_APPEND, 7'd0, INT_MAX);
    send_item(bale_pkg::FN_INSERT, 7'd0, 32'd7);
    // insert past the end appends
    send_item(bale_pkg::FN_INSERT, 7'd127, 32'hFFFF_FFFF);
    send_item(bale_pkg::FN_INSERT, 7'd1, 32'd3);
    send_item(bale_pkg::FN_GET, 7'd1, 32'd0);
    send_item(bale_pkg::FN_GET, 7'd5, 32'd0);
    send_item(bale_pkg::FN_GET, 7'd6, 32'd0);
    send_item(bale_pkg::FN_GET, 7'd127, 32'd0);
    // set skips the bound check
    send_item(bale_pkg::FN_SET, 7'd2, INT_MAX);
    send_item(bale_pkg::FN_MEMBER, 7'd0, 32'd7);
    send_item(bale_pkg::FN_MEMBER, 7'd0, INT_MAX);
    send_item(bale_pkg::FN_MEMBER, 7'd0, 32'd12345);
    send_item(bale_pkg::FN_REMOVE, 7'd0, 32'd0);
    send_item(bale_pkg::FN_REMOVE, 7'd1, 32'd0);
    send_item(bale_pkg::FN_REMOVE, 7'd4, 32'd0);
    send_item(bale_pkg::FN_REMOVE, 7'd64, 32'd0);
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();

    // sender rarely idles, receiver often stalls
    in_idle_pct = 6;
    out_stall_pct = 49;
    set_bounds(-32'sd1000, 32'sd1000);
    run_random(520);
    // inverted bounds accept nothing
    set_bounds(INT_MAX, INT_MIN);
    run_random(40);

    // sender often idles, receiver rarely stalls
    in_idle_pct = 49;
    out_stall_pct = 6;
    set_bounds(INT_MIN, INT_MAX);
    run_random(520);

    // full rate
    in_idle_pct = 0;
    out_stall_pct = 0;
    set_bounds(-32'sd50, 32'sd50);
    run_random(480);
    // equal bounds accept nothing
    set_bounds(32'sd5, 32'sd5);
    run_random(30);

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
